// ===== hdl/stm_pkg.sv =====
package stm_pkg;

   // Result slots one input character can produce: a held tag prefix of up to
   // four characters plus the character itself.
   localparam int MaxResults = 5;
   localparam int HeldMax    = 4;
   localparam int CharW      = 8;
   localparam int ProgW      = 3;
   localparam int CountW     = 3;

   typedef logic [CharW-1:0] char_type;
   typedef logic [1:0]       style_type;
   typedef logic [ProgW-1:0] prog_type;

   localparam style_type STYLE_NORMAL      = 2'd0;
   localparam style_type STYLE_BOLD        = 2'd1;
   localparam style_type STYLE_ITALIC      = 2'd2;
   localparam style_type STYLE_BOLD_ITALIC = 2'd3;

   localparam char_type CH_LBRACK = 8'h5B;
   localparam char_type CH_RBRACK = 8'h5D;
   localparam char_type CH_BSLASH = 8'h5C;
   localparam char_type CH_B      = 8'h62;
   localparam char_type CH_I      = 8'h69;

   localparam prog_type PROG_NONE    = 3'd0;
   localparam prog_type PROG_LBRACK  = 3'd1;
   localparam prog_type PROG_B       = 3'd2;
   localparam prog_type PROG_I       = 3'd3;
   localparam prog_type PROG_BI      = 3'd4;

   typedef struct packed {
      char_type [HeldMax-1:0] chars;
      logic [CountW-1:0]      count;
   } held_type;

   typedef struct packed {
      char_type [MaxResults-1:0] chars;
      logic [CountW-1:0]         length;
   } close_type;

   // Results of one input character, all in one style.
   typedef struct packed {
      char_type [MaxResults-1:0] chars;
      logic [CountW-1:0]         count;
      style_type                 style;
      logic                      msg_end;
      logic                      marker;
   } bundle_type;

   function automatic close_type close_tag(input style_type style);
      close_type t;
      t = '0;
      case (style)
         STYLE_BOLD: begin
            t.chars  = {8'h00, CH_RBRACK, CH_B, CH_BSLASH, CH_LBRACK};
            t.length = 3'd4;
         end
         STYLE_ITALIC: begin
            t.chars  = {8'h00, CH_RBRACK, CH_I, CH_BSLASH, CH_LBRACK};
            t.length = 3'd4;
         end
         STYLE_BOLD_ITALIC: begin
            t.chars  = {CH_RBRACK, CH_I, CH_B, CH_BSLASH, CH_LBRACK};
            t.length = 3'd5;
         end
         default: t = '0;
      endcase
      return t;
   endfunction

   // Characters held back for a partial tag, as released when the match fails.
   function automatic held_type held_prefix(input style_type style, input prog_type prog);
      held_type  h;
      close_type t;
      h = '0;
      t = close_tag(style);
      if (style == STYLE_NORMAL) begin
         unique case (prog)
            PROG_LBRACK: begin
               h.chars[0] = CH_LBRACK;
               h.count    = 3'd1;
            end
            PROG_B: begin
               h.chars[1:0] = {CH_B, CH_LBRACK};
               h.count      = 3'd2;
            end
            PROG_I: begin
               h.chars[1:0] = {CH_I, CH_LBRACK};
               h.count      = 3'd2;
            end
            PROG_BI: begin
               h.chars[2:0] = {CH_I, CH_B, CH_LBRACK};
               h.count      = 3'd3;
            end
            default: h = '0;
         endcase
      end else if (prog < t.length) begin
         h.chars = t.chars[HeldMax-1:0];
         h.count = prog;
      end
      return h;
   endfunction

endpackage

// ===== hdl/stm_decode.sv =====
module stm_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  stm_pkg::char_type   text_char,
   input  logic                message_last,
   output stm_pkg::bundle_type bundle
);

   stm_pkg::style_type style_ff, style_in;
   stm_pkg::prog_type  prog_ff, prog_in;

   always_comb begin
      stm_pkg::close_type tag;
      stm_pkg::held_type  h;
      stm_pkg::style_type ns;
      stm_pkg::prog_type  np;
      stm_pkg::char_type  tag_char;
      logic [stm_pkg::CountW-1:0] n;
      logic taken;

      tag      = stm_pkg::close_tag(style_ff);
      tag_char = (prog_ff < tag.length) ? tag.chars[prog_ff] : 8'h00;
      ns       = style_ff;
      np       = prog_ff;
      taken    = 1'b0;
      n        = '0;
      h        = '0;
      bundle   = '0;

      if (style_ff == stm_pkg::STYLE_NORMAL) begin
         if (prog_ff == stm_pkg::PROG_LBRACK && text_char == stm_pkg::CH_B) begin
            np    = stm_pkg::PROG_B;
            taken = 1'b1;
         end else if (prog_ff == stm_pkg::PROG_LBRACK && text_char == stm_pkg::CH_I) begin
            np    = stm_pkg::PROG_I;
            taken = 1'b1;
         end else if (prog_ff == stm_pkg::PROG_B && text_char == stm_pkg::CH_I) begin
            np    = stm_pkg::PROG_BI;
            taken = 1'b1;
         end else if (prog_ff >= stm_pkg::PROG_B && prog_ff <= stm_pkg::PROG_BI &&
                      text_char == stm_pkg::CH_RBRACK) begin
            // The prefix codes follow the style codes shifted by one.
            ns    = 2'(prog_ff - 3'd1);
            np    = stm_pkg::PROG_NONE;
            taken = 1'b1;
         end
      end else if (prog_ff < tag.length && text_char == tag_char) begin
         np    = prog_ff + 3'd1;
         taken = 1'b1;
         if (np == tag.length) begin
            ns = stm_pkg::STYLE_NORMAL;
            np = stm_pkg::PROG_NONE;
         end
      end

      if (!taken) begin
         h = stm_pkg::held_prefix(style_ff, prog_ff);
         bundle.chars[stm_pkg::HeldMax-1:0] = h.chars;
         n  = h.count;
         np = stm_pkg::PROG_NONE;
         if (text_char == stm_pkg::CH_LBRACK) begin
            np = stm_pkg::PROG_LBRACK;
         end else begin
            bundle.chars[n] = text_char;
            n = n + 3'd1;
         end
      end

      bundle.style = ns;

      if (message_last) begin
         h = stm_pkg::held_prefix(ns, np);
         for (int i = 0; i < stm_pkg::HeldMax; i++) begin
            if (3'(i) < h.count) begin
               bundle.chars[n] = h.chars[i];
               n = n + 3'd1;
            end
         end
         if (n == '0) begin
            bundle.marker = 1'b1;
            bundle.style  = stm_pkg::STYLE_NORMAL;
            n = 3'd1;
         end
         bundle.msg_end = 1'b1;
         ns = stm_pkg::STYLE_NORMAL;
         np = stm_pkg::PROG_NONE;
      end

      bundle.count = n;
      style_in     = ns;
      prog_in      = np;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff <= stm_pkg::STYLE_NORMAL;
         prog_ff  <= stm_pkg::PROG_NONE;
      end else if (advance) begin
         style_ff <= style_in;
         prog_ff  <= prog_in;
      end
   end

endmodule

// ===== hdl/stm_result_buf.sv =====
module stm_result_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  stm_pkg::bundle_type bundle,
   output logic                buf_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output stm_pkg::char_type   rsp_out_char,
   output logic                rsp_char_valid,
   output stm_pkg::style_type  rsp_char_style,
   output logic                rsp_run_last,
   output logic                rsp_message_end
);

   stm_pkg::char_type [stm_pkg::MaxResults-1:0] chars_ff;
   logic [stm_pkg::CountW-1:0] cnt_ff;
   stm_pkg::style_type         style_ff;
   logic                       end_ff;
   logic                       marker_ff;
   logic                       xfer;

   assign rsp_valid = (cnt_ff != '0);
   assign xfer      = rsp_valid && !rsp_stall;
   // Room for a new set of results once the last one left is going out.
   assign buf_free  = (cnt_ff == '0) || (cnt_ff == 3'd1 && !rsp_stall);

   assign rsp_out_char    = chars_ff[0];
   assign rsp_char_valid  = !marker_ff;
   assign rsp_char_style  = style_ff;
   assign rsp_run_last    = (cnt_ff == 3'd1);
   assign rsp_message_end = (cnt_ff == 3'd1) && end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= bundle.count;
      end else if (xfer) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chars_ff  <= bundle.chars;
         style_ff  <= bundle.style;
         end_ff    <= bundle.msg_end;
         marker_ff <= bundle.marker;
      end else if (xfer) begin
         chars_ff <= {8'h00, chars_ff[stm_pkg::MaxResults-1:1]};
      end
   end

endmodule

// ===== hdl/style_tag_markup_splitter.sv =====
// A released character passes through the input register and then the result buffer to rsp.
// Throughput: one input character per cycle while each yields at most one result and rsp
// is not stalled; a character that yields k results holds the buffer until all k are sent.
// Reset is synchronous and active high; it empties the input register and the result buffer
// and returns the span style to normal with no partial tag held.
module style_tag_markup_splitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  stm_pkg::char_type  req_text_char,
   input  logic               req_message_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output stm_pkg::char_type  rsp_out_char,
   output logic               rsp_char_valid,
   output stm_pkg::style_type rsp_char_style,
   output logic               rsp_run_last,
   output logic               rsp_message_end
);

   // Input register. It holds one accepted character until the decode
   // result can be moved into the result buffer.
   logic              in_vld_ff, in_vld_in;
   stm_pkg::char_type in_char_ff;
   logic              in_last_ff;

   stm_pkg::bundle_type bundle;
   logic                buf_free;
   logic                advance;
   logic                accept;

   // A character that releases nothing only updates the tag state, so it
   // moves on even while the result buffer is still draining. Anything else
   // waits until the buffer is empty or its final result is being taken.
   assign advance   = in_vld_ff && ((bundle.count == '0) || buf_free);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_text_char;
         in_last_ff <= req_message_last;
      end
   end

   // Tag matching and release of held characters. The span style and the
   // partial tag progress update when the character in the input register advances.
   stm_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .text_char    (in_char_ff),
      .message_last (in_last_ff),
      .bundle       (bundle)
   );

   // Result buffer: up to five results, sent one per rsp transfer.
   stm_result_buf u_result_buf (
      .clock           (clock),
      .reset           (reset),
      .load            (advance && (bundle.count != '0)),
      .bundle          (bundle),
      .buf_free        (buf_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_char_style  (rsp_char_style),
      .rsp_run_last    (rsp_run_last),
      .rsp_message_end (rsp_message_end)
   );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;

   // One styled character as it leaves the result channel.
   typedef struct packed {
      stm_pkg::char_type  ch;
      logic               valid;
      stm_pkg::style_type style;
      logic               run_last;
      logic               msg_end;
   } glyph_type;

   // One row of the directed table. When known is set, the single result that
   // the character causes is written out in the row; otherwise the predictor
   // supplies it.
   typedef struct packed {
      stm_pkg::char_type c;
      logic              last;
      logic              known;
      glyph_type         exp;
   } stim_row_type;

   localparam glyph_type NoGlyph = '0;
   localparam int        DirCount = 27;

   // Directed sequence: byte extremes, a lone '[' at message end, a bold-italic
   // span whose closing tag breaks on its last character (the largest release),
   // a tag of the wrong kind inside an italic span that stays plain text,
   // a closing tag that ends the message with nothing left to release, and
   // a stray '[' followed by a held prefix that is flushed at message end.
   localparam stim_row_type DirRows [0:DirCount-1] = '{
      '{"A",   1'b1, 1'b1, '{"A",   1'b1, stm_pkg::STYLE_NORMAL, 1'b1, 1'b1}},
      '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, stm_pkg::STYLE_NORMAL, 1'b1, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, stm_pkg::STYLE_NORMAL, 1'b1, 1'b1}},
      '{stm_pkg::CH_LBRACK, 1'b1, 1'b1,
        '{stm_pkg::CH_LBRACK, 1'b1, stm_pkg::STYLE_NORMAL, 1'b1, 1'b1}},
      '{stm_pkg::CH_LBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_B,      1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_I,      1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_RBRACK, 1'b0, 1'b0, NoGlyph},
      '{"w",                1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_LBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_BSLASH, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_B,      1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_I,      1'b0, 1'b0, NoGlyph},
      '{"k",                1'b1, 1'b0, NoGlyph},
      '{stm_pkg::CH_LBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_I,      1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_RBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_LBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_B,      1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_RBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_LBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_BSLASH, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_I,      1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_RBRACK, 1'b1, 1'b1,
        '{8'h00, 1'b0, stm_pkg::STYLE_NORMAL, 1'b1, 1'b1}},
      '{stm_pkg::CH_LBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_LBRACK, 1'b0, 1'b0, NoGlyph},
      '{stm_pkg::CH_B,      1'b1, 1'b0, NoGlyph}
   };

   localparam int RandomItems = 400;
   localparam int HoldCycles  = 300;
   localparam int HoldAt      = DirCount + 120;
   localparam int SecondPause = DirCount + 260;
   localparam int DrainCycles = 24;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   stm_pkg::char_type  req_text_char = '0;
   logic               req_message_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   stm_pkg::char_type  rsp_out_char;
   logic               rsp_char_valid;
   stm_pkg::style_type rsp_char_style;
   logic               rsp_run_last;
   logic               rsp_message_end;

   // Side information that travels with the character currently offered.
   logic      cur_known = 1'b0;
   glyph_type cur_exp = '0;

   // Stimulus, built before reset is released.
   stm_pkg::char_type stim_c [$];
   logic              stim_last [$];
   logic              stim_known [$];
   glyph_type         stim_exp [$];

   // Predictor state and the characters it still expects on the result channel.
   stm_pkg::style_type pred_style = stm_pkg::STYLE_NORMAL;
   stm_pkg::prog_type  pred_prog = stm_pkg::PROG_NONE;
   glyph_type          step_glyphs [0:stm_pkg::MaxResults-1];
   int                 step_n;
   glyph_type          styled_due [$];

   int  mismatch_n = 0;
   int  accepted_n = 0;
   int  cycle_n = 0;
   bit  hold_done = 1'b0;

   style_tag_markup_splitter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_char    (req_text_char),
      .req_message_last (req_message_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_char     (rsp_out_char),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_char_style   (rsp_char_style),
      .rsp_run_last     (rsp_run_last),
      .rsp_message_end  (rsp_message_end)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Characters of the closing tag of a span, and its length.
   function automatic stm_pkg::char_type close_char(stm_pkg::style_type s, int idx);
      case (idx)
         0: return stm_pkg::CH_LBRACK;
         1: return stm_pkg::CH_BSLASH;
         2: return (s == stm_pkg::STYLE_ITALIC) ? stm_pkg::CH_I : stm_pkg::CH_B;
         3: return (s == stm_pkg::STYLE_BOLD_ITALIC) ? stm_pkg::CH_I : stm_pkg::CH_RBRACK;
         default: return stm_pkg::CH_RBRACK;
      endcase
   endfunction

   function automatic int close_len(stm_pkg::style_type s);
      return (s == stm_pkg::STYLE_BOLD_ITALIC) ? 5 : 4;
   endfunction

   task automatic emit(stm_pkg::char_type c, logic valid, stm_pkg::style_type s);
      step_glyphs[step_n] = '{c, valid, s, 1'b0, 1'b0};
      step_n++;
   endtask

   // Give back the characters held for a partial tag, in the given style.
   task automatic release_held(stm_pkg::style_type s, stm_pkg::prog_type p);
      int i;
      if (s == stm_pkg::STYLE_NORMAL) begin
         if (p != stm_pkg::PROG_NONE && p <= stm_pkg::PROG_BI)
            emit(stm_pkg::CH_LBRACK, 1'b1, stm_pkg::STYLE_NORMAL);
         if (p == stm_pkg::PROG_B || p == stm_pkg::PROG_BI)
            emit(stm_pkg::CH_B, 1'b1, stm_pkg::STYLE_NORMAL);
         if (p == stm_pkg::PROG_I || p == stm_pkg::PROG_BI)
            emit(stm_pkg::CH_I, 1'b1, stm_pkg::STYLE_NORMAL);
      end else if (p < close_len(s)) begin
         for (i = 0; i < p; i++)
            emit(close_char(s, i), 1'b1, s);
      end
   endtask

   // Works out the styled characters that one input character releases and
   // advances the span style and the tag match.
   task automatic split_char(stm_pkg::char_type c, logic last);
      stm_pkg::style_type s;
      stm_pkg::prog_type  p;
      bit                 taken;
      s = pred_style;
      p = pred_prog;
      taken = 1'b0;
      step_n = 0;
      if (s == stm_pkg::STYLE_NORMAL) begin
         taken = 1'b1;
         if (p == stm_pkg::PROG_LBRACK && c == stm_pkg::CH_B)
            p = stm_pkg::PROG_B;
         else if (p == stm_pkg::PROG_LBRACK && c == stm_pkg::CH_I)
            p = stm_pkg::PROG_I;
         else if (p == stm_pkg::PROG_B && c == stm_pkg::CH_I)
            p = stm_pkg::PROG_BI;
         else if (p == stm_pkg::PROG_B && c == stm_pkg::CH_RBRACK) begin
            s = stm_pkg::STYLE_BOLD;
            p = stm_pkg::PROG_NONE;
         end else if (p == stm_pkg::PROG_I && c == stm_pkg::CH_RBRACK) begin
            s = stm_pkg::STYLE_ITALIC;
            p = stm_pkg::PROG_NONE;
         end else if (p == stm_pkg::PROG_BI && c == stm_pkg::CH_RBRACK) begin
            s = stm_pkg::STYLE_BOLD_ITALIC;
            p = stm_pkg::PROG_NONE;
         end else
            taken = 1'b0;
      end else if (p < close_len(s) && c == close_char(s, p)) begin
         p = p + 1'b1;
         if (p == close_len(s)) begin
            s = stm_pkg::STYLE_NORMAL;
            p = stm_pkg::PROG_NONE;
         end
         taken = 1'b1;
      end

      // A character that does not extend the tag gives back what was held and
      // is then taken as text, unless it is a '[' that may start a new tag.
      if (!taken) begin
         release_held(s, p);
         p = stm_pkg::PROG_NONE;
         if (c == stm_pkg::CH_LBRACK)
            p = stm_pkg::PROG_LBRACK;
         else
            emit(c, 1'b1, s);
      end

      // The end of a message flushes the held characters and forgets the span.
      // With nothing released an empty marker stands in for the message end.
      if (last) begin
         release_held(s, p);
         if (step_n == 0)
            emit(8'h00, 1'b0, stm_pkg::STYLE_NORMAL);
         step_glyphs[step_n-1].msg_end = 1'b1;
         s = stm_pkg::STYLE_NORMAL;
         p = stm_pkg::PROG_NONE;
      end
      if (step_n > 0)
         step_glyphs[step_n-1].run_last = 1'b1;
      pred_style = s;
      pred_prog = p;
   endtask

   // Mostly no gap, often a short one, now and then a long one. One stretch in
   // five of the cycle count runs with no idling at all.
   function automatic int pick_gap();
      int r;
      if ((cycle_n / 200) % 5 == 4)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 62)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_item(stm_pkg::char_type c, logic last, logic known, glyph_type exp);
      stim_c = {stim_c, c};
      stim_last = {stim_last, last};
      stim_known = {stim_known, known};
      stim_exp = {stim_exp, exp};
   endtask

   // Character idx of a markup tag: kinds 0 to 2 open bold, italic and
   // bold-italic, kinds 3 to 5 close them.
   function automatic stm_pkg::char_type tag_char(int kind, int idx);
      if (kind >= 3)
         return close_char(stm_pkg::style_type'(kind - 2), idx);
      if (idx == 0)
         return stm_pkg::CH_LBRACK;
      if (idx == ((kind == 2) ? 3 : 2))
         return stm_pkg::CH_RBRACK;
      if (kind == 1 || idx == 2)
         return stm_pkg::CH_I;
      return stm_pkg::CH_B;
   endfunction

   function automatic int tag_len(int kind);
      if (kind >= 3)
         return close_len(stm_pkg::style_type'(kind - 2));
      return (kind == 2) ? 4 : 3;
   endfunction

   // Random messages are mostly well-formed markup with random text between
   // the tags, mixed with truncated tags, wrong closing tags and stray tag
   // characters.
   task automatic build_stimulus();
      stm_pkg::char_type msg [$];
      int                i, j, ntok, sel, kind, len, made, span;
      for (i = 0; i < DirCount; i++)
         add_item(DirRows[i].c, DirRows[i].last, DirRows[i].known, DirRows[i].exp);
      made = 0;
      while (made < RandomItems) begin
         msg.delete();
         span = 0;
         ntok = $urandom_range(1, 10);
         for (i = 0; i < ntok; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
               msg = {msg, stm_pkg::char_type'($urandom_range(0, 255))};
            end else if (sel < 92) begin
               if (sel < 55) begin
                  kind = $urandom_range(0, 2);
                  if (span == 0)
                     span = kind + 1;
               end else if (sel < 80) begin
                  if (span != 0 && $urandom_range(0, 9) < 7) begin
                     kind = span + 2;
                     span = 0;
                  end else
                     kind = $urandom_range(3, 5);
               end else
                  kind = $urandom_range(0, 5);
               len = tag_len(kind);
               // Truncated tags stop short of their final character.
               if (sel >= 80)
                  len = $urandom_range(1, len - 1);
               for (j = 0; j < len; j++)
                  msg = {msg, tag_char(kind, j)};
            end else begin
               case ($urandom_range(0, 4))
                  0: msg = {msg, stm_pkg::CH_LBRACK};
                  1: msg = {msg, stm_pkg::CH_BSLASH};
                  2: msg = {msg, stm_pkg::CH_B};
                  3: msg = {msg, stm_pkg::CH_I};
                  default: msg = {msg, stm_pkg::CH_RBRACK};
               endcase
            end
         end
         for (i = 0; i < msg.size(); i++)
            add_item(msg[i], i == msg.size() - 1, 1'b0, NoGlyph);
         made += msg.size();
      end
   endtask

   // Sender: releases reset, then offers every character in order.
   initial begin
      int k, gap;
      bit pause;
      build_stimulus();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (k = 0; k < stim_c.size(); k++) begin
         gap = pick_gap();
         // Twice the sender stops until the block has delivered everything,
         // so that a character also arrives at a fully drained block.
         pause = (k == DirCount) || (k == SecondPause);
         if (gap > 0 || pause) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (pause && styled_due.size() != 0)
               @(negedge clock);
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_text_char <= stim_c[k];
         req_message_last <= stim_last[k];
         cur_known <= stim_known[k];
         cur_exp <= stim_exp[k];
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         @(negedge clock);
      end
      req_valid <= 1'b0;

      while (styled_due.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_n == 0 && styled_due.size() == 0)
         $display("** style_tag_markup_splitter: PASSED **");
      else
         $display("** style_tag_markup_splitter: FAILED **");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off once the run is under
   // way so that the result buffer fills and the block stalls its input.
   initial begin
      int gap;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!hold_done && accepted_n >= HoldAt) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   // Monitor: both channels are sampled at the rising edge. An accepted
   // character is run through the predictor at once; a row of the directed
   // table that carries its own result expects that result instead, while
   // the predictor still advances its state.
   always @(posedge clock) begin
      glyph_type got, want;
      int        i;
      cycle_n <= cycle_n + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            accepted_n <= accepted_n + 1;
            split_char(req_text_char, req_message_last);
            if (cur_known)
               styled_due = {styled_due, cur_exp};
            else
               for (i = 0; i < step_n; i++)
                  styled_due = {styled_due, step_glyphs[i]};
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_char, rsp_char_valid, rsp_char_style, rsp_run_last,
                    rsp_message_end};
            if (styled_due.size() == 0) begin
               mismatch_n++;
               if (mismatch_n <= 10)
                  $display("unexpected transfer: char %02h valid %0b style %0d last %0b end %0b",
                           got.ch, got.valid, got.style, got.run_last, got.msg_end);
            end else begin
               want = styled_due.pop_front();
               if (got != want) begin
                  mismatch_n++;
                  if (mismatch_n <= 10)
                     $display("mismatch at %0t: exp %02h/%0b/%0d/%0b/%0b got %02h/%0b/%0d/%0b/%0b",
                              $realtime, want.ch, want.valid, want.style, want.run_last,
                              want.msg_end, got.ch, got.valid, got.style, got.run_last,
                              got.msg_end);
               end
            end
         end
      end
   end

   // Run limit, well above the slowest correct run.
   initial begin
      #5000000;
      $display("** style_tag_markup_splitter: FAILED **");
      $finish;
   end

endmodule
